// File: sv/ras_pkg.sv
package ras_pkg;
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV,
    ST_AVG_WR,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_OUT_RD,
    ST_OUT_ELEM,
    ST_OUT_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_READ,
    PH_DONE
  } phase_t;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;
endpackage

// File: sv/ras_ram.sv
module ras_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write-first: a read of the entry being written returns the new word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
  end
endmodule

// File: sv/row_average_sorter.sv
// Row average sorter. Load transactions (func=0) store one signed Q16.16
// element each; row_end closes a row, set_end closes the row and the set.
// At set end the block averages every row (sum / count, truncated toward
// zero) and orders the rows by ascending average with an i<j exchange sort.
// Read transactions (func=1) then return the sorted rows element by element.
// start is taken when busy is low; each read yields exactly one result, shown
// for one cycle with done high, which the receiver cannot stall. Loads
// produce no result.
// Steps: a read passes through the order memory read, the average memory
// read and row length lookup, then the element read. At set end the element
// memory is read one word a cycle for the sums, a 36-step restoring divider
// forms each average, and each sort compare reads the order and average
// memories and, on a swap, writes the swapped pair back.
module row_average_sorter #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic signed [31:0] value,
  input  logic               row_end,
  input  logic               set_end,
  output logic               done,
  output logic signed [31:0] value_res,
  output logic signed [31:0] average,
  output logic [3:0]         rank,
  output logic [3:0]         column,
  output logic               last_in_row,
  output logic               last_in_set,
  output logic               status,
  output logic               overflow
);
  import ras_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int EW  = $clog2(MAX_ROWS * MAX_COLS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int SW  = 32 + CW;           // sum width
  localparam int DIVW = SW;               // quotient bits

  state_t state, state_next;
  phase_t phase;
  logic [RCW-1:0] row_count;
  logic [CW-1:0]  column_count;
  logic [RW-1:0]  read_rank;
  logic [CW-1:0]  read_column;
  logic           overflow_seen;

  // row lengths kept in flops (cleared at reset, read at a fixed port each)
  logic [CW-1:0] row_length [MAX_ROWS];

  // element memory
  logic              e_we;
  logic [EW-1:0]     e_waddr, e_raddr;
  logic [31:0]       e_rdata;
  // average memory
  logic              a_we;
  logic [RW-1:0]     a_waddr, a_raddr;
  logic [31:0]       a_rdata;
  // order memory (two copies give two read ports)
  logic              o_we;
  logic [RW-1:0]     o_waddr, o_raddr0, o_raddr1;
  logic [RW-1:0]     o_wdata, o_rdata0, o_rdata1;

  // working registers
  logic [RW-1:0]          row_idx;     // averaging row, sort i
  logic [RW-1:0]          j_idx;       // sort j
  logic [CW-1:0]          k_idx;
  logic                   avg_end;     // every row averaged
  logic signed [SW-1:0]   sum;
  logic [SW-1:0]          rem_mag, quot;
  logic [SW-1:0]          num_mag;
  logic                   neg;
  logic [$clog2(DIVW+1)-1:0] div_cnt;
  logic [RW-1:0]          ord_i, ord_j;
  logic signed [31:0]     avg_i;
  logic                   wr_second;
  logic [RW-1:0]          out_row;
  logic [CW-1:0]          out_len;
  logic signed [31:0]     out_avg;

  ras_ram #(.WIDTH(32), .DEPTH(MAX_ROWS * MAX_COLS)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(value),
    .raddr(e_raddr), .rdata(e_rdata));
  ras_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_avg (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(quot[31:0]),
    .raddr(a_raddr), .rdata(a_rdata));
  ras_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_ord0 (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr0), .rdata(o_rdata0));
  ras_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_ord1 (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr1), .rdata(o_rdata1));

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // load path helpers
  logic           abandon;
  logic [RCW-1:0] ld_rows;
  logic [CW-1:0]  ld_cols;
  logic           ld_store;
  assign abandon  = (phase != PH_LOAD);
  assign ld_rows  = abandon ? '0 : row_count;
  assign ld_cols  = abandon ? '0 : column_count;
  assign ld_store = (ld_rows < RCW'(MAX_ROWS)) && (ld_cols < CW'(MAX_COLS));

  logic [EW-1:0] wr_base;
  assign wr_base = EW'(ld_rows[RW-1:0] * MAX_COLS);

  // one restoring divide step on magnitudes
  logic [SW:0] trial;
  assign trial = {1'b0, rem_mag[SW-2:0], num_mag[SW-1]} -
                 {1'b0, {(SW-CW){1'b0}}, row_length[row_idx]};

  // sort compare: average at i strictly above average at j
  logic swap_now;
  assign swap_now = avg_i > signed'(a_rdata);

  // a read with nothing to return answers at once with status set
  logic rd_empty;
  assign rd_empty = !(phase == PH_READ && {1'b0, read_rank} < row_count);

  always_comb begin
    state_next = state;
    e_we    = 1'b0;
    e_waddr = wr_base + EW'(ld_cols);
    e_raddr = EW'(row_idx * MAX_COLS) + EW'(k_idx);
    a_we    = 1'b0;
    a_waddr = row_idx;
    a_raddr = o_rdata0;
    o_we    = 1'b0;
    o_waddr = row_idx;
    o_wdata = row_idx;
    o_raddr0 = row_idx;
    o_raddr1 = j_idx;
    unique case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_LOAD) begin
          e_we = ld_store;
          if (set_end) begin
            state_next = ST_SUM_RD;
          end
        end else if (accept) begin
          o_raddr0 = read_rank;
          if (!rd_empty) begin
            state_next = ST_OUT_RD;
          end
        end
      end
      ST_SUM_RD: begin
        if (avg_end) begin
          state_next = (row_count > RCW'(1)) ? ST_SORT_RD : ST_IDLE;
          o_raddr0 = '0;
          o_raddr1 = RW'(1);
        end else begin
          state_next = ST_SUM_ACC;
        end
      end
      ST_SUM_ACC: begin
        if (k_idx == row_length[row_idx]) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_AVG_WR;
        end
      end
      ST_AVG_WR: begin
        a_we    = 1'b1;
        o_we    = 1'b1;
        state_next = ST_SUM_RD;
      end
      ST_SORT_RD: begin
        // order data present; fetch average at i
        a_raddr = o_rdata0;
        state_next = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        a_raddr = ord_j;
        state_next = ST_SORT_WR;
      end
      ST_SORT_WR: begin
        if (swap_now && !wr_second) begin
          o_we = 1'b1;
          o_waddr = row_idx;
          o_wdata = ord_j;
        end else begin
          if (wr_second) begin
            o_we = 1'b1;
            o_waddr = j_idx;
            o_wdata = ord_i;
          end
          if ({1'b0, j_idx} + RCW'(1) < row_count) begin
            o_raddr0 = row_idx;
            o_raddr1 = j_idx + RW'(1);
            state_next = ST_SORT_RD;
          end else if ({1'b0, row_idx} + RCW'(2) < row_count) begin
            o_raddr0 = row_idx + RW'(1);
            o_raddr1 = row_idx + RW'(2);
            state_next = ST_SORT_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_OUT_RD: begin
        a_raddr = o_rdata0;
        state_next = ST_OUT_ELEM;
      end
      ST_OUT_ELEM: begin
        e_raddr = EW'(out_row * MAX_COLS) +
                  EW'((read_column < CW'(MAX_COLS)) ? read_column : CW'(MAX_COLS - 1));
        state_next = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic lr, ls;
  assign lr = ({1'b0, read_column} + 1'b1) >= {1'b0, out_len};
  assign ls = lr && (({1'b0, read_rank} + RCW'(1)) >= row_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LOAD;
      row_count     <= '0;
      column_count  <= '0;
      read_rank     <= '0;
      read_column   <= '0;
      overflow_seen <= 1'b0;
      done          <= 1'b0;
      for (int r = 0; r < MAX_ROWS; r++) begin
        row_length[r] <= '0;
      end
    end else begin
      done <= (state == ST_OUT_EMIT) ||
              (state == ST_IDLE && accept && func == FUNC_READ && rd_empty);
      unique case (state)
        ST_IDLE: begin
          if (accept && func == FUNC_LOAD) begin
            logic [RCW-1:0] rc;
            logic [CW-1:0]  cc;
            rc = ld_rows;
            cc = ld_cols;
            if (ld_store) begin
              cc = cc + CW'(1);
            end
            if (abandon || !ld_store) begin
              overflow_seen <= !ld_store;
            end
            if (row_end || set_end) begin
              if (rc < RCW'(MAX_ROWS) && cc != '0) begin
                row_length[rc[RW-1:0]] <= cc;
                rc = rc + RCW'(1);
              end
              cc = '0;
            end
            row_count    <= rc;
            column_count <= cc;
            if (set_end) begin
              read_rank   <= '0;
              read_column <= '0;
              phase       <= (rc != '0) ? PH_READ : PH_DONE;
            end else begin
              phase       <= PH_LOAD;
            end
            row_idx <= '0;
            avg_end <= (rc == '0);
          end else if (accept) begin
            value_res   <= '0;
            average     <= '0;
            rank        <= '0;
            column      <= '0;
            last_in_row <= 1'b0;
            last_in_set <= 1'b0;
            status      <= 1'b1;
            overflow    <= overflow_seen;
          end
          k_idx <= '0;
          sum   <= '0;
        end
        ST_SUM_RD: begin
          k_idx <= CW'(1);
          if (avg_end) begin
            row_idx <= '0;
            j_idx   <= RW'(1);
            wr_second <= 1'b0;
          end
        end
        ST_SUM_ACC: begin
          sum   <= sum + SW'(signed'(e_rdata));
          k_idx <= k_idx + CW'(1);
          if (k_idx == row_length[row_idx]) begin
            neg     <= (sum + SW'(signed'(e_rdata))) < 0;
            num_mag <= (sum + SW'(signed'(e_rdata))) < 0 ?
                       SW'(-(sum + SW'(signed'(e_rdata)))) :
                       SW'(sum + SW'(signed'(e_rdata)));
            rem_mag <= '0;
            div_cnt <= ($bits(div_cnt))'(DIVW);
          end
        end
        ST_DIV: begin
          if (div_cnt == '0) begin
            quot <= neg ? -quot : quot;
          end else begin
            num_mag <= {num_mag[SW-2:0], 1'b0};
            if (!trial[SW]) begin
              rem_mag <= trial[SW-1:0];
              quot    <= {quot[SW-2:0], 1'b1};
            end else begin
              rem_mag <= {rem_mag[SW-2:0], num_mag[SW-1]};
              quot    <= {quot[SW-2:0], 1'b0};
            end
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_AVG_WR: begin
          row_idx <= row_idx + RW'(1);
          avg_end <= ({1'b0, row_idx} + RCW'(1)) >= row_count;
          k_idx   <= '0;
          sum     <= '0;
        end
        ST_SORT_RD: begin
          ord_i <= o_rdata0;
          ord_j <= o_rdata1;
        end
        ST_SORT_CMP: begin
          avg_i <= a_rdata;
        end
        ST_SORT_WR: begin
          if (swap_now && !wr_second) begin
            wr_second <= 1'b1;
          end else begin
            wr_second <= 1'b0;
            if ({1'b0, j_idx} + RCW'(1) < row_count) begin
              j_idx <= j_idx + RW'(1);
            end else begin
              row_idx <= row_idx + RW'(1);
              j_idx   <= row_idx + RW'(2);
            end
          end
        end
        ST_OUT_RD: begin
          out_row <= o_rdata0;
          out_len <= row_length[o_rdata0];
        end
        ST_OUT_ELEM: begin
          out_avg <= a_rdata;
        end
        ST_OUT_EMIT: begin
          value_res   <= e_rdata;
          average     <= out_avg;
          rank        <= 4'(read_rank);
          column      <= 4'(read_column);
          last_in_row <= lr;
          last_in_set <= ls;
          status      <= 1'b0;
          overflow    <= overflow_seen;
          if (ls) begin
            phase <= PH_DONE;
          end else if (lr) begin
            read_rank   <= read_rank + RW'(1);
            read_column <= '0;
          end else begin
            read_column <= read_column + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule
